// ----- rtl/sks_pkg.sv -----
// shared types and constants for the sorted key set
package sks_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_REMOVE   = 2'd1;
  localparam logic [1:0] KIND_CONTAINS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
  } in_t;

  typedef struct packed {
    logic [4:0] position;
    logic       present;
    logic       changed;
    logic [4:0] count;
    logic       is_full;
    logic       is_empty;
  } out_t;

  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic                 sgn;
    logic [KEY_WIDTH-1:0] key;
  } cell_ctl_t;

endpackage

// ----- rtl/sks_cell.sv -----
// one compare-and-shift cell holding a single stored key
module sks_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sks_pkg::cell_ctl_t             ctl,
  input  logic [sks_pkg::KEY_WIDTH-1:0]  left_key,
  input  logic                           left_vld,
  input  logic [sks_pkg::KEY_WIDTH-1:0]  right_key,
  input  logic                           right_vld,
  input  logic                           found_i,
  output logic                           found_o,
  output logic                           hit_o,
  output logic                           match_o,
  output logic [sks_pkg::KEY_WIDTH-1:0]  key_o,
  output logic                           vld_o
);
  import sks_pkg::*;

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 vld_r, vld_nxt;
  logic [KEY_WIDTH-1:0] flip;
  logic                 lt;
  logic                 ge;

  assign flip    = {ctl.sgn, {(KEY_WIDTH-1){1'b0}}};
  assign lt      = vld_r && ((key_r ^ flip) < (ctl.key ^ flip));
  assign ge      = !lt;
  assign hit_o   = ge && !found_i;
  assign found_o = found_i || ge;
  assign match_o = hit_o && vld_r && (key_r == ctl.key);
  assign key_o   = key_r;
  assign vld_o   = vld_r;

  always_comb begin
    key_nxt = key_r;
    vld_nxt = vld_r;
    if (ctl.ins) begin
      if (found_i) begin
        key_nxt = left_key;
        vld_nxt = left_vld;
      end else if (hit_o) begin
        key_nxt = ctl.key;
        vld_nxt = 1'b1;
      end
    end else if (ctl.rem && found_o) begin
      key_nxt = right_key;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

// ----- rtl/sorted_key_set.sv -----
// sorted key set: ordered store of distinct keys with insert, remove and lookup
//
// Requests arrive on in_valid/in_ready with in_data (kind, key); one result per
// request leaves on out_valid/out_ready with out_data. A request is taken into
// an input register and executed when the output register is free: every cell
// of the row compares its key against the request key at once, the lower bound
// is found along the cell chain, and insert or remove shifts the cells by one in
// that same cycle. The result is registered in the output register and shown on
// out_valid; one request per cycle is sustained while out_ready stays high.
// When the receiver stalls, the result waits in the output register, one more
// request waits in the input register, and then in_ready drops until the
// result is taken. Reset empties the set, sets the capacity limit to 16 and
// selects unsigned ordering; it needs no clearing pass. Configuration writes
// through cfg_we/cfg_addr/cfg_wdata take effect at once; the user must make them
// only while no request is in flight, and the block itself does not enforce this.
module sorted_key_set (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sks_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sks_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [sks_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [sks_pkg::CFG_W-1:0]       cfg_wdata
);
  import sks_pkg::*;

  in_t              req_r;
  logic             req_vld_r;
  out_t             out_r, out_nxt;
  logic             out_vld_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_r;
  logic             sgn_r;
  logic             exec;
  logic [CNT_W-1:0] limit;
  logic             room;
  logic             present;
  logic             any_hit;
  logic [CNT_W-1:0] lb;
  logic [1:0]       kind;
  logic             is_ins;
  logic             is_rem;
  cell_ctl_t        ctl;

  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]     cell_vld;
  logic [DEPTH-1:0]     cell_hit;
  logic [DEPTH-1:0]     cell_match;
  logic [DEPTH:0]       found;

  assign exec     = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !req_vld_r || exec;
  assign kind     = req_r.kind;
  assign limit    = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;
  assign room     = count_r < limit;
  assign present  = |cell_match;
  assign any_hit  = |cell_hit;

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (kind)
      KIND_INSERT: is_ins = 1'b1;
      KIND_REMOVE: is_rem = 1'b1;
      default:     ;
    endcase
  end

  assign ctl.ins = exec && is_ins && room && !present;
  assign ctl.rem = exec && is_rem && present;
  assign ctl.sgn = sgn_r;
  assign ctl.key = req_r.key[KEY_WIDTH-1:0];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] lk, rk;
    logic                 lv, rv;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = 1'b0;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lv = cell_vld[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rv = cell_vld[i+1];
    end
    sks_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_key  (lk),
      .left_vld  (lv),
      .right_key (rk),
      .right_vld (rv),
      .found_i   (found[i]),
      .found_o   (found[i+1]),
      .hit_o     (cell_hit[i]),
      .match_o   (cell_match[i]),
      .key_o     (cell_key[i]),
      .vld_o     (cell_vld[i])
    );
  end

  always_comb begin
    lb = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_hit[i]) begin
        lb = lb | CNT_W'(i);
      end
    end
    if (!any_hit) begin
      lb = CNT_W'(DEPTH);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt.position = (is_ins && !room) ? limit : lb;
    out_nxt.present  = present;
    out_nxt.changed  = ctl.ins || ctl.rem;
    out_nxt.count    = count_nxt;
    out_nxt.is_full  = count_nxt >= limit;
    out_nxt.is_empty = count_nxt == '0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
      cap_r     <= CNT_W'(16);
      sgn_r     <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req_vld_r <= 1'b1;
      end else if (exec) begin
        req_vld_r <= 1'b0;
      end
      if (exec) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_CAPACITY: cap_r <= cfg_wdata;
          REG_ORDER:    sgn_r <= cfg_wdata[0];
          default:      ;
        endcase
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/sks_check.sv -----
// port-level assertions for the sorted key set, bound to the top level
module sks_check (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input sks_pkg::in_t                   in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input sks_pkg::out_t                  out_data
);
  import sks_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.is_empty == (out_data.count == 5'd0))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.count <= 5'(DEPTH))
    else $error("count beyond store depth");

  a_kept_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.present && !out_data.changed |-> !out_data.is_empty)
    else $error("present key kept but set reads empty");

endmodule

bind sorted_key_set sks_check u_sks_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
